FILE: rtl/core/ccl_pkg.sv
// Shared types and constants for the constant-cache line reservation block.
// No dependencies; imported by ccl_cell and constant_cache_line_reservation.

package ccl_pkg;

  localparam int MAX_SETS   = 4;
  localparam int SET_CNT_W  = $clog2(MAX_SETS + 1);
  localparam int BANK_W     = 4;
  localparam int IDX_W      = 12;
  localparam int LINE_SHIFT = 4;
  // line can grow by two per set walked past, so one bit above the index line
  localparam int LINE_W     = 9;
  localparam int IMODE_W    = 2;
  localparam int ACT_W      = 3;

  localparam logic [ACT_W-1:0] ACTIVE_SETS_RESET = 3'd4;

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  localparam logic [IMODE_W-1:0] IMODE_NONE = 2'd0;
  localparam logic [IMODE_W-1:0] IMODE_IR0  = 2'd1;
  localparam logic [IMODE_W-1:0] IMODE_IR1  = 2'd2;

  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_ONE,
    MODE_TWO
  } lock_mode_t;

  typedef struct packed {
    lock_mode_t         mode;
    logic [BANK_W-1:0]  bank;
    logic [LINE_W-1:0]  line;
    logic [IMODE_W-1:0] imode;
  } lock_set_t;

  typedef struct packed {
    logic               valid;
    logic [BANK_W-1:0]  bank;
    logic [LINE_W-1:0]  line;
    logic [IMODE_W-1:0] imode;
  } token_t;

  typedef struct packed {
    logic commit;
    logic revert;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic ok;
    logic insert;
  } cell_stat_t;

  typedef struct packed {
    logic               cmd;
    logic [BANK_W-1:0]  bank;
    logic [IDX_W-1:0]   const_index;
    logic [IMODE_W-1:0] idx_mode;
    logic               last_in_group;
  } ccl_req_t;

  typedef struct packed {
    logic ok;
    logic alloc_failed;
    logic committed;
  } ccl_rsp_t;

endpackage

FILE: rtl/core/constant_cache_line_reservation.sv
// Top level of the constant-cache line reservation block: controller and row of lock-set cells.
// Depends on ccl_pkg and ccl_cell.

// Keeps up to MAX_SETS constant-cache lock sets sorted by bank, then line, one set per
// cell in a row of ccl_cell instances. A reserve word launches a request token into the
// first cell; each cycle the token moves one cell along, and the cell holding it either
// takes the request (fills a free set, widens a set to two lines, or inserts, with the
// later cells each loading their left neighbour), refuses it, or passes the token on.
// Every cell keeps a working and a committed copy; the last word of a group commits the
// working copies if the group succeeded, a failure reverts them at once and the rest of
// the group is answered with ok low. A clear word empties both copies. One word is in
// work at a time: a reserve walks from launch until a cell settles it, the token stepping
// one cell per cycle; clear words, words of an already failed group and reserves with
// active_sets at zero skip the walk. active_sets above MAX_SETS acts as MAX_SETS. The
// response sits in an output register, so a stalled response does not hold back the
// walk of the next word, only its completion. active_sets is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while the block is idle, and the
// block itself does not enforce it.

module constant_cache_line_reservation (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ccl_pkg::ACT_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ccl_pkg::ccl_req_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ccl_pkg::ccl_rsp_t         out_data
);
  import ccl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [ACT_W-1:0]      active_sets;
  logic [SET_CNT_W-1:0]  n_eff;
  ccl_req_t              req;
  ccl_req_t              in_norm;
  logic                  skip;       // group had already failed when the word came in
  logic                  walk_ok;
  logic                  group_failed;
  logic                  failed_flag;

  lock_set_t             work_set [MAX_SETS];
  token_t                tok      [MAX_SETS+1];
  cell_stat_t            stat     [MAX_SETS];
  logic [MAX_SETS-1:0]   cell_active;
  logic [MAX_SETS-1:0]   cell_last;
  logic [MAX_SETS-1:0]   shift_in;
  logic [MAX_SETS-1:0]   done_vec;
  logic [MAX_SETS-1:0]   tok_live;
  logic                  tail_full;
  logic                  any_done;
  logic                  any_ok;
  cell_ctl_t             ctl;
  logic                  in_take;
  logic                  finish_go;
  logic                  start_skip;

  // active_sets saturates at the row length
  always_comb begin
    if (int'(active_sets) > MAX_SETS) begin
      n_eff = SET_CNT_W'(MAX_SETS);
    end else begin
      n_eff = SET_CNT_W'(active_sets);
    end
  end

  // index mode three behaves as index register 1
  always_comb begin
    in_norm = in_data;
    if (in_data.idx_mode[1]) begin
      in_norm.idx_mode = IMODE_IR1;
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign finish_go  = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign start_skip = (in_data.cmd == CMD_CLEAR) || group_failed || (n_eff == '0);

  // token into the first cell in the launch cycle
  always_comb begin
    tok[0].valid = (state == ST_LAUNCH);
    tok[0].bank  = req.bank;
    tok[0].line  = LINE_W'(req.const_index[IDX_W-1:LINE_SHIFT]);
    tok[0].imode = req.idx_mode;
  end

  // row-wide combine: tail occupancy, insert shift, completion
  always_comb begin
    tail_full = 1'b0;
    any_done  = 1'b0;
    any_ok    = 1'b0;
    shift_in  = '0;
    for (int k = 0; k < MAX_SETS; k++) begin
      done_vec[k] = stat[k].done;
      tok_live[k] = tok[k+1].valid;
      if (cell_last[k] && work_set[k].mode != MODE_FREE) begin
        tail_full = 1'b1;
      end
      if (stat[k].done) begin
        any_done = 1'b1;
        any_ok   = any_ok | stat[k].ok;
      end
      if (k > 0) begin
        shift_in[k] = shift_in[k-1] | stat[k-1].insert;
      end
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.clear  = finish_go && (req.cmd == CMD_CLEAR);
    ctl.commit = finish_go && (req.cmd == CMD_RESERVE) && !skip && walk_ok &&
                 req.last_in_group;
    ctl.revert = finish_go && (req.cmd == CMD_RESERVE) && !skip && !walk_ok;
  end

  for (genvar k = 0; k < MAX_SETS; k++) begin : g_cell
    lock_set_t left;
    assign cell_active[k] = int'(n_eff) > k;
    assign cell_last[k]   = int'(n_eff) == (k + 1);
    if (k == 0) begin : g_first
      assign left = '{mode: MODE_FREE, bank: '0, line: '0, imode: IMODE_NONE};
    end else begin : g_rest
      assign left = work_set[k-1];
    end
    ccl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .active    (cell_active[k]),
      .last      (cell_last[k]),
      .tail_full (tail_full),
      .shift_in  (shift_in[k]),
      .left      (left),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1]),
      .stat      (stat[k]),
      .set_out   (work_set[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_sets  <= ACTIVE_SETS_RESET;
      group_failed <= 1'b0;
      failed_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_sets <= cfg_wr_data;
      end
      // a new response in the same cycle keeps the register full
      if (out_valid && !out_stall && !finish_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            req     <= in_norm;
            skip    <= group_failed && (in_data.cmd == CMD_RESERVE);
            walk_ok <= 1'b0;
            state   <= start_skip ? ST_FINISH : ST_LAUNCH;
          end
        end
        ST_LAUNCH, ST_WALK: begin
          if (any_done) begin
            walk_ok <= any_ok;
            state   <= ST_FINISH;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (req.cmd == CMD_CLEAR) begin
              out_data     <= '{ok: 1'b1, alloc_failed: failed_flag, committed: 1'b0};
              group_failed <= 1'b0;
            end else if (skip) begin
              out_data <= '{ok: 1'b0, alloc_failed: failed_flag, committed: 1'b0};
              if (req.last_in_group) begin
                group_failed <= 1'b0;
              end
            end else if (walk_ok) begin
              out_data <= '{ok: 1'b1,
                            alloc_failed: failed_flag && !req.last_in_group,
                            committed: req.last_in_group};
              if (req.last_in_group) begin
                failed_flag <= 1'b0;
              end
            end else begin
              out_data     <= '{ok: 1'b0, alloc_failed: 1'b1, committed: 1'b0};
              failed_flag  <= 1'b1;
              group_failed <= !req.last_in_group;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the last active cell always settles the walk, so no token runs off the row
  a_tok_contained: assert property (@(posedge clk) disable iff (rst)
    !tok[MAX_SETS].valid)
    else $error("request token left the cell row");

  // only the cell holding the token may settle the request
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec))
    else $error("more than one cell settled a request");

  // while walking, the token is somewhere in the row
  a_tok_alive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (tok_live != '0))
    else $error("request token lost during walk");

  // a commit only follows a fully successful group
  a_commit_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.committed) |-> (out_data.ok && !out_data.alloc_failed))
    else $error("commit reported with failure");

  // the tables are touched by only one row-wide command at a time
  a_ctl_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.commit, ctl.revert, ctl.clear}) && !(any_done && finish_go))
    else $error("conflicting row commands");

endmodule

FILE: rtl/core/ccl_cell.sv
// One lock-set cell: working and committed copy of a set, plus the request token stage.
// Depends on ccl_pkg.

module ccl_cell (
  input  logic              clk,
  input  logic              rst,
  input  ccl_pkg::cell_ctl_t ctl,
  input  logic              active,
  input  logic              last,
  input  logic              tail_full,
  input  logic              shift_in,
  input  ccl_pkg::lock_set_t left,
  input  ccl_pkg::token_t   tok_in,
  output ccl_pkg::token_t   tok_out,
  output ccl_pkg::cell_stat_t stat,
  output ccl_pkg::lock_set_t set_out
);
  import ccl_pkg::*;

  lock_set_t work;
  lock_set_t comm;
  lock_set_t wr_set;
  logic      wr_en;
  logic      pass;
  token_t    tok_next;
  token_t    tok_q;
  logic [LINE_W:0] s_line;
  logic [LINE_W:0] t_line;

  assign s_line = {1'b0, work.line};
  assign t_line = {1'b0, tok_in.line};

  always_comb begin
    stat     = '0;
    wr_en    = 1'b0;
    wr_set   = work;
    pass     = 1'b0;
    tok_next = tok_in;
    if (tok_in.valid && active) begin
      if (work.mode == MODE_FREE) begin
        wr_en  = 1'b1;
        wr_set = '{mode: MODE_ONE, bank: tok_in.bank, line: tok_in.line, imode: tok_in.imode};
        stat.done = 1'b1;
        stat.ok   = 1'b1;
      end else if (work.bank < tok_in.bank) begin
        pass = 1'b1;
      end else if (work.bank == tok_in.bank && work.imode != IMODE_NONE &&
                   work.imode != tok_in.imode) begin
        stat.done = 1'b1;
      end else if (work.bank > tok_in.bank || s_line > t_line + 1'b1) begin
        stat.done = 1'b1;
        if (!tail_full) begin
          wr_en  = 1'b1;
          wr_set = '{mode: MODE_ONE, bank: tok_in.bank, line: tok_in.line,
                     imode: tok_in.imode};
          stat.ok     = 1'b1;
          stat.insert = 1'b1;
        end
      end else if (s_line == t_line + 1'b1) begin
        // request sits just below this set: extend downwards
        wr_en       = 1'b1;
        wr_set.line = work.line - 1'b1;
        if (work.mode == MODE_TWO) begin
          pass          = 1'b1;
          tok_next.line = LINE_W'(t_line + 2'd2);
        end else begin
          wr_set.mode = MODE_TWO;
          stat.done   = 1'b1;
          stat.ok     = 1'b1;
        end
      end else if (t_line == s_line + 1'b1) begin
        wr_en       = 1'b1;
        wr_set.mode = MODE_TWO;
        stat.done   = 1'b1;
        stat.ok     = 1'b1;
      end else if (t_line == s_line) begin
        stat.done = 1'b1;
        stat.ok   = 1'b1;
      end else begin
        pass = 1'b1;
      end
      if (pass && last) begin
        stat.done = 1'b1;
      end
    end
    tok_next.valid = pass && !last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work.mode   <= MODE_FREE;
      comm.mode   <= MODE_FREE;
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_next;
      if (ctl.clear) begin
        work.mode <= MODE_FREE;
        comm.mode <= MODE_FREE;
      end else if (ctl.revert) begin
        work <= comm;
      end else if (ctl.commit) begin
        comm <= work;
      end else if (shift_in && active) begin
        work <= left;
      end else if (wr_en) begin
        work <= wr_set;
      end
    end
  end

  assign tok_out = tok_q;
  assign set_out = work;

endmodule
